// ===== rtl/core/bftl_pkg.sv =====
package bftl_pkg;

    localparam int BUCKET_COUNT = 4096;
    localparam int MAX_ENTRIES  = 4096;
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int LINK_W = IDX_W + 1;
    localparam int ENTRY_W = 32 + 32 + 32 + 8 + LINK_W + 32;
    localparam logic [31:0] HASH_MUL = 32'h045d_9f3b;
    localparam logic [12:0] LIMIT_RESET = 13'd4096;

    localparam logic [1:0] ST_FOUND   = 2'd0;
    localparam logic [1:0] ST_CREATED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MIX1, S_MIX2, S_MIX3, S_HEAD, S_HEADW,
        S_ENTRY, S_ENTRYW, S_CHECK, S_INSERT, S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input word, canonicalize
        logic mix1;
        logic mix2;
        logic mix3;       // final fold, bucket index
        logic head_rd;
        logic head_take;  // link <= head data
        logic entry_rd;
        logic entry_take; // compare + next link
        logic insert;
        logic set_full;
        logic set_found;
        logic clr_wr;
    } bftl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic link_zero;
        logic hit;
        logic full;
        logic clr_done;
    } bftl_sts_t;

    function automatic logic [31:0] swap_bytes(input logic [31:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// ===== rtl/core/bidirectional_flow_table_lookup.sv =====
// Per word: hash mix steps, bucket head fetch, chain walk over the entries, then
// an insert on a miss when the table is not full; a hit ends the walk early.
// Throughput: one word at a time; next word accepted the cycle after the
// result is taken. Chain length per bucket sets the rate.
// Reset (aresetn, synchronous, active low): flow count cleared, limit to 4096,
// then a clear pass zeroes all 4096 bucket heads before the first word is taken.
module bidirectional_flow_table_lookup import bftl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_dst_ip,
    input  logic [15:0] s_src_port,
    input  logic [15:0] s_dst_port,
    input  logic [7:0]  s_ip_proto,
    input  logic [31:0] s_now_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_flow_index,
    output logic [1:0]  m_status,
    output logic [31:0] m_first_seen
);
    bftl_cmd_t cmd;
    bftl_sts_t sts;

    // sequencer: clear pass, hash, head fetch, chain walk, insert
    bftl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .sts(sts), .cmd(cmd)
    );

    // tuple registers, multiplier, bucket and entry RAMs
    bftl_dpath u_dpath (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_src_ip(s_src_ip), .s_dst_ip(s_dst_ip), .s_src_port(s_src_port),
        .s_dst_port(s_dst_port), .s_ip_proto(s_ip_proto), .s_now_time(s_now_time),
        .m_flow_index(m_flow_index), .m_status(m_status), .m_first_seen(m_first_seen)
    );

    // never ready and valid at once
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and valid overlap");
    // status is a legal code when shown
    a_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_FOUND || m_status == ST_CREATED || m_status == ST_FULL))
        else $error("bad status");
    // full result carries zero fields
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_flow_index == '0 && m_first_seen == '0))
        else $error("full result not zero");
endmodule

// ===== rtl/core/bftl_ram.sv =====
module bftl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/bftl_ctrl.sv =====
module bftl_ctrl import bftl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bftl_sts_t sts,
    output bftl_cmd_t cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:  if (sts.clr_done) state_next = S_IDLE;
            S_IDLE:   if (s_valid) state_next = S_MIX1;
            S_MIX1:   state_next = S_MIX2;
            S_MIX2:   state_next = S_MIX3;
            S_MIX3:   state_next = S_HEAD;
            S_HEAD:   state_next = S_HEADW;
            S_HEADW:  state_next = S_CHECK;
            S_ENTRY:  state_next = S_ENTRYW;
            S_ENTRYW: state_next = sts.hit ? S_OUT : S_CHECK;
            S_CHECK:  begin
                if (!sts.link_zero) state_next = S_ENTRY;
                else if (sts.full)  state_next = S_OUT;
                else                state_next = S_INSERT;
            end
            S_INSERT: state_next = S_OUT;
            S_OUT:    if (m_ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            S_CLEAR:  cmd.clr_wr = 1'b1;
            S_IDLE:   begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_MIX1:   cmd.mix1 = 1'b1;
            S_MIX2:   cmd.mix2 = 1'b1;
            S_MIX3:   cmd.mix3 = 1'b1;
            S_HEAD:   cmd.head_rd = 1'b1;
            S_HEADW:  cmd.head_take = 1'b1;
            S_ENTRY:  cmd.entry_rd = 1'b1;
            S_ENTRYW: begin
                cmd.entry_take = 1'b1;
                cmd.set_found  = sts.hit;
            end
            S_CHECK:  cmd.set_full = sts.link_zero && sts.full;
            S_INSERT: cmd.insert = 1'b1;
            S_OUT:    m_valid = 1'b1;
            default:  cmd = '0;
        endcase
    end
endmodule

// ===== rtl/core/bftl_dpath.sv =====
module bftl_dpath import bftl_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  bftl_cmd_t         cmd,
    output bftl_sts_t         sts,
    input  logic              cfg_we,
    input  logic [12:0]       cfg_wdata,
    input  logic [31:0]       s_src_ip,
    input  logic [31:0]       s_dst_ip,
    input  logic [15:0]       s_src_port,
    input  logic [15:0]       s_dst_port,
    input  logic [7:0]        s_ip_proto,
    input  logic [31:0]       s_now_time,
    output logic [11:0]       m_flow_index,
    output logic [1:0]        m_status,
    output logic [31:0]       m_first_seen
);
    logic [31:0]       lo_reg, hi_reg, ports_reg, now_reg, h_reg;
    logic [7:0]        proto_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LINK_W-1:0] link_reg;
    logic [12:0]       limit_reg, count_reg;
    logic [BKT_W:0]    clr_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [1:0]        status_reg;
    logic [31:0]       seen_reg;

    logic [LINK_W-1:0] head_rdata;
    logic [ENTRY_W-1:0] ent_rdata, ent_wdata;
    logic              swap;
    logic [31:0]       h0, hx;
    logic [IDX_W-1:0]  cur_idx;
    logic [31:0]       e_lo, e_hi, e_ports, e_time;
    logic [7:0]        e_proto;
    logic [LINK_W-1:0] e_next;
    logic              head_we;
    logic [BKT_W-1:0]  head_waddr;
    logic [LINK_W-1:0] head_wdata;
    logic [13:0]       lim_eff;

    assign swap = (swap_bytes(s_src_ip) > swap_bytes(s_dst_ip))
               || (s_src_ip == s_dst_ip && s_src_port > s_dst_port);
    assign h0 = swap ? (s_dst_ip ^ s_src_ip ^ {s_dst_port, s_src_port} ^ {24'd0, s_ip_proto})
                     : (s_src_ip ^ s_dst_ip ^ {s_src_port, s_dst_port} ^ {24'd0, s_ip_proto});
    assign hx = h_reg ^ {16'd0, h_reg[31:16]};

    assign cur_idx = link_reg[IDX_W-1:0] - 1'b1;
    assign {e_lo, e_hi, e_ports, e_proto, e_next, e_time} = ent_rdata;
    // head RAM still reads the bucket's old head here: new entry links to it
    assign ent_wdata = {lo_reg, hi_reg, ports_reg, proto_reg, head_rdata, now_reg};

    assign lim_eff = (limit_reg > 13'(MAX_ENTRIES)) ? 14'(MAX_ENTRIES) : {1'b0, limit_reg};
    assign sts.full = {1'b0, count_reg} >= lim_eff;
    assign sts.link_zero = (link_reg == '0);
    assign sts.hit = (e_lo == lo_reg) && (e_hi == hi_reg) && (e_ports == ports_reg)
                  && (e_proto == proto_reg);
    assign sts.clr_done = clr_reg[BKT_W];

    assign head_we    = cmd.clr_wr || cmd.insert;
    assign head_waddr = cmd.clr_wr ? clr_reg[BKT_W-1:0] : bkt_reg;
    assign head_wdata = cmd.clr_wr ? '0 : LINK_W'(count_reg[IDX_W-1:0]) + 1'b1;

    bftl_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_COUNT)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(bkt_reg), .rdata(head_rdata)
    );

    bftl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry (
        .aclk(aclk), .we(cmd.insert), .waddr(count_reg[IDX_W-1:0]), .wdata(ent_wdata),
        .raddr(cur_idx), .rdata(ent_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
            count_reg <= '0;
            clr_reg   <= '0;
        end else begin
            if (cfg_we) limit_reg <= cfg_wdata;
            if (cmd.insert) count_reg <= count_reg + 1'b1;
            if (cmd.clr_wr && !clr_reg[BKT_W]) clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg    <= swap ? s_dst_ip : s_src_ip;
            hi_reg    <= swap ? s_src_ip : s_dst_ip;
            ports_reg <= swap ? {s_dst_port, s_src_port} : {s_src_port, s_dst_port};
            proto_reg <= s_ip_proto;
            now_reg   <= s_now_time;
            h_reg     <= h0;
        end
        if (cmd.mix1 || cmd.mix2) h_reg <= hx * HASH_MUL;
        if (cmd.mix3) bkt_reg <= hx[BKT_W-1:0];
        if (cmd.head_take) link_reg <= head_rdata;
        if (cmd.entry_take) begin
            link_reg <= e_next;
            idx_reg  <= cur_idx;
        end
        if (cmd.set_found) begin
            status_reg <= ST_FOUND;
            seen_reg   <= e_time;
        end
        if (cmd.set_full) begin
            status_reg <= ST_FULL;
            idx_reg    <= '0;
            seen_reg   <= '0;
        end
        if (cmd.insert) begin
            status_reg <= ST_CREATED;
            idx_reg    <= count_reg[IDX_W-1:0];
            seen_reg   <= now_reg;
        end
    end

    assign m_flow_index = 12'(idx_reg);
    assign m_status     = status_reg;
    assign m_first_seen = seen_reg;
endmodule
